// ----- rtl/core/bbro_pkg.sv -----
// Shared types, constants and raster-op logic for the raster-op blit block.
`default_nettype none
package bbro_pkg;

  localparam int unsigned ROW_W   = 10;
  localparam int unsigned WCOL_W  = 5;
  localparam int unsigned ADDR_W  = ROW_W + WCOL_W;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SPAN_W  = 11;
  localparam int unsigned LINES   = 1024;
  localparam int unsigned LINE_PIXELS = 1024;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_BLIT  = 2'd2;

  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] LOW_ONES = 32'h7FFF_FFFF;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  // GX code: bit0 s&d, bit1 s&~d, bit2 ~s&d, bit3 ~s&~d
  function automatic logic [DATA_W-1:0] rop_apply(input logic [3:0] code,
                                                  input logic [DATA_W-1:0] s,
                                                  input logic [DATA_W-1:0] d);
    rop_apply = ({DATA_W{code[0]}} &  s &  d) |
                ({DATA_W{code[1]}} &  s & ~d) |
                ({DATA_W{code[2]}} & ~s &  d) |
                ({DATA_W{code[3]}} & ~s & ~d);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bbro_if.sv -----
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface bbro_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [14:0] word_addr;
  logic [31:0] word_data;
  logic [9:0]  src_row;
  logic [9:0]  src_col;
  logic [9:0]  dst_row;
  logic [9:0]  dst_col;
  logic [10:0] rect_height;
  logic [10:0] rect_width;
  logic [3:0]  rop;
  modport source(output valid, op, word_addr, word_data, src_row, src_col, dst_row,
                 dst_col, rect_height, rect_width, rop, input ready);
  modport sink(input valid, op, word_addr, word_data, src_row, src_col, dst_row,
               dst_col, rect_height, rect_width, rop, output ready);
endinterface

interface bbro_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        out_of_range;
  modport source(output valid, read_data, out_of_range, input ready);
  modport sink(input valid, read_data, out_of_range, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bbro_frame_ram.sv -----
// Single-port frame store, 32768 x 32, registered read.
`default_nettype none
module bbro_frame_ram (
  input  wire logic                       clk_i,
  input  wire bbro_pkg::mem_req_t         req_i,
  output logic [bbro_pkg::DATA_W-1:0]     rdata_o
);

  logic [bbro_pkg::DATA_W-1:0] mem [2**bbro_pkg::ADDR_W];
  logic [bbro_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.addr] <= req_i.wdata;
    if (req_i.re) rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/bbro_seq.sv -----
// Request sequencer: word access, blit read-modify-write walk, result register.
`default_nettype none
module bbro_seq (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  bbro_in_if.sink                      in_i,
  bbro_out_if.source                   out_o,
  output bbro_pkg::mem_req_t           mem_req_o,
  input  wire logic [bbro_pkg::DATA_W-1:0] mem_rdata_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDW  = 3'd1;
  localparam logic [2:0] ST_SA   = 3'd2;
  localparam logic [2:0] ST_SB   = 3'd3;
  localparam logic [2:0] ST_SD   = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int unsigned RW = bbro_pkg::ROW_W;
  localparam int unsigned CW = bbro_pkg::WCOL_W;
  localparam int unsigned DW = bbro_pkg::DATA_W;

  logic [2:0]     state_q, state_d;
  logic [RW-1:0]  srow_q, srow_d, drow_q, drow_d;
  logic [RW-1:0]  scol_q, scol_d, dcol_q, dcol_d;
  logic [RW-1:0]  dlast_q, dlast_d;
  logic [CW-1:0]  cw_q, cw_d, wstart_q, wstart_d, wend_q, wend_d;
  logic [CW-1:0]  wfirst_q, wfirst_d, wlast_q, wlast_d;
  logic [bbro_pkg::SPAN_W-1:0] rem_q, rem_d;
  logic           rows_up_q, rows_up_d, cols_bk_q, cols_bk_d;
  logic [3:0]     rop_q, rop_d;
  logic [DW-1:0]  a_q, a_d, b_q, b_d;
  logic [DW-1:0]  res_rd_q, res_rd_d;
  logic           res_oor_q, res_oor_d;
  logic           ov_q, ov_d;
  logic [DW-1:0]  ord_q, ord_d;
  logic           ooor_q, ooor_d;

  logic           in_xfer;
  logic [11:0]    s_bot, d_bot, s_rgt, d_rgt;
  logic [RW-1:0]  dlast_n;
  logic           oor;
  logic [11:0]    sbase;
  logic [6:0]     sw, swb;
  logic [CW-1:0]  cola, colb;
  logic [4:0]     lo, hi;
  logic [DW-1:0]  mask, src_al, newd;
  logic [2*DW-1:0] pair_sh;

  function automatic logic [CW-1:0] clamp_col(input logic [6:0] v);
    if (v[6]) clamp_col = '0;
    else if (v[5]) clamp_col = '1;
    else clamp_col = v[CW-1:0];
  endfunction

  assign in_xfer = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign s_bot = {2'b00, in_i.src_row} + {1'b0, in_i.rect_height};
  assign d_bot = {2'b00, in_i.dst_row} + {1'b0, in_i.rect_height};
  assign s_rgt = {2'b00, in_i.src_col} + {1'b0, in_i.rect_width};
  assign d_rgt = {2'b00, in_i.dst_col} + {1'b0, in_i.rect_width};
  assign dlast_n = d_rgt[RW-1:0] - 10'd1;
  assign oor = (s_bot > 12'(bbro_pkg::LINES)) || (d_bot > 12'(bbro_pkg::LINES)) ||
               (s_rgt > 12'(bbro_pkg::LINE_PIXELS)) || (d_rgt > 12'(bbro_pkg::LINE_PIXELS));

  assign sbase = {2'b00, cw_q, 5'b00000} + {2'b00, scol_q} - {2'b00, dcol_q};
  assign sw    = sbase[11:5];
  assign swb   = sw + 7'd1;
  assign cola  = clamp_col(sw);
  assign colb  = clamp_col(swb);

  assign lo   = (cw_q == wfirst_q) ? dcol_q[4:0] : 5'd0;
  assign hi   = (cw_q == wlast_q) ? dlast_q[4:0] : 5'd31;
  assign mask = (bbro_pkg::ALL_ONES >> lo) & ~(bbro_pkg::LOW_ONES >> hi);
  assign pair_sh = {a_q, b_q} << sbase[4:0];
  assign src_al  = pair_sh[2*DW-1:DW];
  assign newd = (mask & bbro_pkg::rop_apply(rop_q, src_al, mem_rdata_i)) |
                (~mask & mem_rdata_i);

  always_comb begin
    state_d = state_q;
    srow_d = srow_q; drow_d = drow_q; scol_d = scol_q; dcol_d = dcol_q;
    dlast_d = dlast_q; cw_d = cw_q; wstart_d = wstart_q; wend_d = wend_q;
    wfirst_d = wfirst_q; wlast_d = wlast_q; rem_d = rem_q;
    rows_up_d = rows_up_q; cols_bk_d = cols_bk_q; rop_d = rop_q;
    a_d = a_q; b_d = b_q; res_rd_d = res_rd_q; res_oor_d = res_oor_q;
    ov_d = ov_q; ord_d = ord_q; ooor_d = ooor_q;
    mem_req_o = '0;

    if (out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          res_rd_d  = '0;
          res_oor_d = 1'b0;
          state_d   = ST_DONE;
          unique case (in_i.op)
            bbro_pkg::OP_WRITE: begin
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = in_i.word_addr;
              mem_req_o.wdata = in_i.word_data;
            end
            bbro_pkg::OP_READ: begin
              mem_req_o.re   = 1'b1;
              mem_req_o.addr = in_i.word_addr;
              state_d        = ST_RDW;
            end
            bbro_pkg::OP_BLIT: begin
              if (in_i.rect_height != '0 && in_i.rect_width != '0) begin
                if (oor) begin
                  res_oor_d = 1'b1;
                end else begin
                  rows_up_d = in_i.dst_row > in_i.src_row;
                  cols_bk_d = (in_i.dst_row == in_i.src_row) && (in_i.dst_col > in_i.src_col);
                  srow_d = (in_i.dst_row > in_i.src_row) ? s_bot[RW-1:0] - 10'd1 : in_i.src_row;
                  drow_d = (in_i.dst_row > in_i.src_row) ? d_bot[RW-1:0] - 10'd1 : in_i.dst_row;
                  scol_d = in_i.src_col;
                  dcol_d = in_i.dst_col;
                  dlast_d = dlast_n;
                  wfirst_d = in_i.dst_col[RW-1:RW-CW];
                  wlast_d  = dlast_n[RW-1:RW-CW];
                  if ((in_i.dst_row == in_i.src_row) && (in_i.dst_col > in_i.src_col)) begin
                    wstart_d = dlast_n[RW-1:RW-CW];
                    wend_d   = in_i.dst_col[RW-1:RW-CW];
                  end else begin
                    wstart_d = in_i.dst_col[RW-1:RW-CW];
                    wend_d   = dlast_n[RW-1:RW-CW];
                  end
                  cw_d   = wstart_d;
                  rem_d  = in_i.rect_height;
                  rop_d  = in_i.rop;
                  state_d = ST_SA;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RDW: begin
        res_rd_d = mem_rdata_i;
        state_d  = ST_DONE;
      end
      ST_SA: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = {srow_q, cola};
        state_d        = ST_SB;
      end
      ST_SB: begin
        a_d            = mem_rdata_i;
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = {srow_q, colb};
        state_d        = ST_SD;
      end
      ST_SD: begin
        b_d            = mem_rdata_i;
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = {drow_q, cw_q};
        state_d        = ST_WR;
      end
      ST_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = {drow_q, cw_q};
        mem_req_o.wdata = newd;
        state_d         = ST_SA;
        if (cw_q == wend_q) begin
          cw_d  = wstart_q;
          rem_d = rem_q - 11'd1;
          if (rows_up_q) begin
            srow_d = srow_q - 10'd1;
            drow_d = drow_q - 10'd1;
          end else begin
            srow_d = srow_q + 10'd1;
            drow_d = drow_q + 10'd1;
          end
          if (rem_q == 11'd1) state_d = ST_DONE;
        end else begin
          cw_d = cols_bk_q ? cw_q - 5'd1 : cw_q + 5'd1;
        end
      end
      ST_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          ord_d   = res_rd_q;
          ooor_d  = res_oor_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    srow_q <= srow_d; drow_q <= drow_d; scol_q <= scol_d; dcol_q <= dcol_d;
    dlast_q <= dlast_d; cw_q <= cw_d; wstart_q <= wstart_d; wend_q <= wend_d;
    wfirst_q <= wfirst_d; wlast_q <= wlast_d; rem_q <= rem_d;
    rows_up_q <= rows_up_d; cols_bk_q <= cols_bk_d; rop_q <= rop_d;
    a_q <= a_d; b_q <= b_d; res_rd_q <= res_rd_d; res_oor_q <= res_oor_d;
    ord_q <= ord_d; ooor_q <= ooor_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.read_data    = ord_q;
  assign out_o.out_of_range = ooor_q;

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == ST_IDLE || state_q == ST_WR))
    else $error("frame write outside idle or write-back");
  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR |-> mem_req_o.addr == $past(mem_req_o.addr))
    else $error("write-back address differs from destination read");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && ov_q && !out_o.ready) |=> state_q == ST_DONE)
    else $error("result dropped while output stalled");
  a_oor_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.op == bbro_pkg::OP_BLIT && oor) |=> state_q == ST_DONE)
    else $error("rejected blit touched the frame");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/bit_blit_raster_op.sv -----
// Monochrome frame store with word access and raster-op rectangle blit.
// Channels: in_i carries one request per transfer (op, word fields, blit
// rectangle, GX raster-op code); out_o returns exactly one result per
// request (read_data for a word read, out_of_range for a rejected blit).
// Frame: 1024 lines of 32 words, pixel x at bit 31-(x mod 32), MSB first.
// Each destination word costs two source reads, one destination read and
// one write on the single frame memory port. One request is in flight at
// a time; in_i.ready is high while the sequencer is idle, even when a
// finished result still waits in the output register. If out_o stalls,
// the next result is held until the output register frees. Reset clears
// control state only; the frame store holds undefined data until written.
// Overlapping blits pick the scan direction so that every source pixel is
// read before it is overwritten.
`default_nettype none
module bit_blit_raster_op (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bbro_in_if.sink    in_i,
  bbro_out_if.source out_o
);

  bbro_pkg::mem_req_t          mem_req;
  logic [bbro_pkg::DATA_W-1:0] mem_rdata;

  bbro_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .mem_req_o  (mem_req),
    .mem_rdata_i(mem_rdata)
  );

  bbro_frame_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

endmodule
`default_nettype wire
